### hdl/x86_64_instruction_encoder_unit_assert.svh
// assertion macros shared by the checker of the instruction encoder
// no dependencies
`ifndef X86_64_INSTRUCTION_ENCODER_UNIT_ASSERT_SVH
`define X86_64_INSTRUCTION_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define X86ENC_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("x86enc check failed");

// next-cycle implication
`define X86ENC_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("x86enc check failed");

`endif

### hdl/x86enc_pkg.sv
// types, codes and register tables of the x86-64 instruction encoder
// no dependencies
package x86enc_pkg;

  localparam int MaxBytes      = 10;
  localparam int HdrBytes      = 6;
  localparam int DefQueueDepth = 2;

  typedef enum logic [3:0] {
    ACT_AND_IMM = 4'd0,
    ACT_CALL    = 4'd1,
    ACT_LEA     = 4'd2,
    ACT_LEAVE   = 4'd3,
    ACT_MOV_IMM = 4'd4,
    ACT_MOV_REG = 4'd5,
    ACT_MOVQ    = 4'd6,
    ACT_POP     = 4'd7,
    ACT_PUSH    = 4'd8,
    ACT_RET     = 4'd9
  } act_t;

  // register index map
  localparam logic [6:0] REG_RAX   = 7'd0;
  localparam logic [6:0] R64_LAST  = 7'd15;
  localparam logic [6:0] REG_EAX   = 7'd16;
  localparam logic [6:0] R32_LAST  = 7'd23;
  localparam logic [6:0] REG_AX    = 7'd24;
  localparam logic [6:0] R16_LAST  = 7'd31;
  localparam logic [6:0] REG_AL    = 7'd32;
  localparam logic [6:0] REG_AH    = 7'd36;
  localparam logic [6:0] R8_LAST   = 7'd39;
  localparam logic [6:0] MMX_LAST  = 7'd47;
  localparam logic [6:0] XMM_BASE  = 7'd48;
  localparam logic [6:0] XMM_LAST  = 7'd63;
  localparam logic [6:0] YMM_LAST  = 7'd79;

  // opcode and prefix bytes
  localparam logic [7:0] PFX_OPSIZE   = 8'h66;
  localparam logic [7:0] PFX_ADDRSIZE = 8'h67;
  localparam logic [7:0] REX_BASE     = 8'h40;
  localparam logic [7:0] REX_W        = 8'h48;
  localparam logic [7:0] REX_B        = 8'h41;
  localparam logic [7:0] OP_AND_AL    = 8'h24;
  localparam logic [7:0] OP_AND_AX    = 8'h25;
  localparam logic [7:0] OP_GRP1_B    = 8'h80;
  localparam logic [7:0] OP_GRP1_Z    = 8'h81;
  localparam logic [7:0] OP_GRP1_S8   = 8'h83;
  localparam logic [7:0] OP_MOV_RM_B  = 8'h88;
  localparam logic [7:0] OP_MOV_RM    = 8'h89;
  localparam logic [7:0] OP_LEA       = 8'h8D;
  localparam logic [7:0] OP_MOV_IMM_B = 8'hB0;
  localparam logic [7:0] OP_MOV_IMM   = 8'hB8;
  localparam logic [7:0] OP_PUSH      = 8'h50;
  localparam logic [7:0] OP_POP       = 8'h58;
  localparam logic [7:0] OP_GRP5      = 8'hFF;
  localparam logic [7:0] MODRM_CALL   = 8'hD0;
  localparam logic [7:0] MODRM_AND    = 8'hE0;
  localparam logic [7:0] MODRM_REG    = 8'hC0;
  localparam logic [7:0] SIB_NOINDEX  = 8'h24;
  localparam logic [7:0] OP_ESC       = 8'h0F;
  localparam logic [7:0] OP_MOVQ_TO   = 8'h6E;
  localparam logic [7:0] OP_MOVQ_FROM = 8'h7E;
  localparam logic [7:0] OP_RET       = 8'hC3;
  localparam logic [7:0] OP_LEAVE     = 8'hC9;
  localparam logic [2:0] RM_DISP_ONLY = 3'd5;
  localparam logic [2:0] RM_SIB       = 3'd4;

  // low code of gpr groups, entry 0 at the right
  localparam logic [7:0][2:0] GprLo  = {3'd4, 3'd5, 3'd7, 3'd6, 3'd2, 3'd1, 3'd3, 3'd0};
  localparam logic [7:0][2:0] ByteLo = {3'd6, 3'd5, 3'd7, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0};

  // hardware register code of a register index
  function automatic logic [3:0] reg_code(logic [6:0] r);
    logic [3:0] c;
    if (r < 7'd8) c = {1'b0, GprLo[r[2:0]]};
    else if (r <= R64_LAST) c = {1'b1, r[2:0]};
    else if (r <= R16_LAST) c = {1'b0, GprLo[r[2:0]]};
    else if (r <= R8_LAST) c = {1'b0, ByteLo[r[2:0]]};
    else if (r <= MMX_LAST) c = {1'b0, r[2:0]};
    else if (r <= YMM_LAST) c = r[3:0];
    else c = 4'd0;
    return c;
  endfunction

  // one encoded instruction
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [3:0]               len;
    logic                     ok;
  } enc_rec_t;

  // front to queue
  typedef struct packed {
    logic     push;
    enc_rec_t rec;
  } q_wr_t;

  // queue head to back
  typedef struct packed {
    logic     valid;
    enc_rec_t rec;
  } q_rd_t;

endpackage

### hdl/x86enc_if.sv
// channel interfaces of the instruction encoder: request in, code bytes out
// depends on nothing
interface x86enc_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [6:0]  dst_reg;
  logic [6:0]  src_reg;
  logic [63:0] immediate;

  modport source (output valid, action, dst_reg, src_reg, immediate, input ready);
  modport sink (input valid, action, dst_reg, src_reg, immediate, output ready);
endinterface

interface x86enc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       ok;

  modport source (output valid, out_byte, last_byte, ok, input ready);
  modport sink (input valid, out_byte, last_byte, ok, output ready);
endinterface

### hdl/x86_64_instruction_encoder_unit.sv
// top level of the x86-64 instruction encoder: front, queue and serializer
// depends on x86enc_pkg, x86enc_if, x86enc_front, x86enc_queue, x86enc_back
//
//  channel | dir | payload                               | per transfer
//  --------+-----+---------------------------------------+---------------------
//  instr   | in  | action, dst_reg, src_reg, immediate   | one request
//  code    | out | out_byte, last_byte, ok               | one machine code byte
//
// an instruction of n bytes (1 to 10) goes out on the code channel, one
// byte per cycle from the serializer's output register while code is ready;
// a request is taken whenever the queue has room and is held there as a record
// synchronous reset empties the queue and the output register, no clearing pass
// a stall on code holds the byte; requests keep coming until the queue is full
module x86_64_instruction_encoder_unit
  import x86enc_pkg::*;
#(
  parameter int QueueDepth = DefQueueDepth
) (
  input  logic clk,
  input  logic rst,
  x86enc_req_if.sink    instr,
  x86enc_byte_if.source code
);

  q_wr_t wr;
  q_rd_t rd;
  logic  full;
  logic  pop;

  // classify and encode the whole instruction in the cycle it arrives
  x86enc_front u_front (
    .instr (instr),
    .full  (full),
    .wr    (wr)
  );

  // encoded records wait here while the serializer is busy or stalled
  x86enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .full (full),
    .rd   (rd)
  );

  // one byte per transfer; record leaves the queue with its last byte
  x86enc_back u_back (
    .clk  (clk),
    .rst  (rst),
    .rd   (rd),
    .pop  (pop),
    .code (code)
  );

endmodule

### hdl/x86enc_front.sv
// front end: accepts a request and encodes it into a full byte record
// depends on x86enc_pkg and x86enc_if
module x86enc_front
  import x86enc_pkg::*;
(
  x86enc_req_if.sink instr,
  input  logic       full,
  output q_wr_t      wr
);

  logic [6:0]  dst, src;
  logic [63:0] imm;
  logic [3:0]  dc, sc, xc, gc;
  logic        d64, d32, d16, d8, dint, dxmm, s64, s32, sxmm;
  logic        f8, f16, f32;
  logic [7:0]  m_and, rex_and, opq;
  logic [3:0]  lrex;
  logic [1:0]  lmod;
  logic [HdrBytes-1:0][7:0] hdr;
  logic [2:0]  hn;
  logic [3:0]  il;
  logic        ok;
  logic [3:0]  j;

  assign dst = instr.dst_reg;
  assign src = instr.src_reg;
  assign imm = instr.immediate;
  assign dc  = reg_code(dst);
  assign sc  = reg_code(src);

  assign d64  = dst <= R64_LAST;
  assign d32  = dst >= REG_EAX && dst <= R32_LAST;
  assign d16  = dst >= REG_AX && dst <= R16_LAST;
  assign d8   = dst >= REG_AL && dst <= R8_LAST;
  assign dint = dst <= R8_LAST;
  assign dxmm = dst >= XMM_BASE && dst <= XMM_LAST;
  assign s64  = src <= R64_LAST;
  assign s32  = src >= REG_EAX && src <= R32_LAST;
  assign sxmm = src >= XMM_BASE && src <= XMM_LAST;

  // signed range checks: all bits above the field equal its sign
  assign f8  = (&imm[63:7]) | ~(|imm[63:7]);
  assign f16 = (&imm[63:15]) | ~(|imm[63:15]);
  assign f32 = (&imm[63:31]) | ~(|imm[63:31]);

  assign m_and   = MODRM_AND | {5'd0, dc[2:0]};
  assign rex_and = REX_W | {7'd0, dc[3]};

  // movq operand roles: xmm in modrm.reg, gpr in modrm.rm
  assign xc  = dxmm ? dc : sc;
  assign gc  = dxmm ? sc : dc;
  assign opq = dxmm ? OP_MOVQ_TO : OP_MOVQ_FROM;

  // rex bits w, r, x, b
  assign lrex = {d64, dc[3], 1'b0, sc[3]};

  always_comb begin
    hdr  = '0;
    hn   = 3'd0;
    il   = 4'd0;
    ok   = 1'b0;
    lmod = 2'd0;
    case (act_t'(instr.action))
      ACT_AND_IMM: begin
        if (dint && f32) begin
          ok = 1'b1;
          if (dst == REG_AL && f8) begin
            hdr[0] = OP_AND_AL; hn = 3'd1; il = 4'd1;
          end else if (dst == REG_AX && f16) begin
            hdr[0] = PFX_OPSIZE; hdr[1] = OP_AND_AX; hn = 3'd2; il = 4'd2;
          end else if (dst == REG_EAX) begin
            hdr[0] = OP_AND_AX; hn = 3'd1; il = 4'd4;
          end else if (dst == REG_RAX) begin
            hdr[0] = REX_W; hdr[1] = OP_AND_AX; hn = 3'd2; il = 4'd4;
          end else if (f8) begin
            il = 4'd1;
            if (d8) begin
              // high byte registers have no encoding here
              if (dst >= REG_AH) ok = 1'b0;
              else begin
                hdr[0] = OP_GRP1_B; hdr[1] = m_and; hn = 3'd2;
              end
            end else if (d16) begin
              hdr[0] = PFX_OPSIZE; hdr[1] = OP_GRP1_S8; hdr[2] = m_and; hn = 3'd3;
            end else if (d32) begin
              hdr[0] = OP_GRP1_S8; hdr[1] = m_and; hn = 3'd2;
            end else begin
              hdr[0] = rex_and; hdr[1] = OP_GRP1_S8; hdr[2] = m_and; hn = 3'd3;
            end
          end else if (d16 && f16) begin
            hdr[0] = PFX_OPSIZE; hdr[1] = OP_GRP1_Z; hdr[2] = m_and; hn = 3'd3; il = 4'd2;
          end else if (d8 || d16) begin
            ok = 1'b0;
          end else if (d32) begin
            hdr[0] = OP_GRP1_Z; hdr[1] = m_and; hn = 3'd2; il = 4'd4;
          end else begin
            hdr[0] = rex_and; hdr[1] = OP_GRP1_Z; hdr[2] = m_and; hn = 3'd3; il = 4'd4;
          end
        end
      end
      ACT_CALL, ACT_POP, ACT_PUSH: begin
        if (d64) begin
          ok = 1'b1;
          if (dc[3]) begin
            hdr[hn] = REX_B; hn = hn + 3'd1;
          end
          if (act_t'(instr.action) == ACT_CALL) begin
            hdr[hn] = OP_GRP5; hn = hn + 3'd1;
            hdr[hn] = MODRM_CALL | {5'd0, dc[2:0]}; hn = hn + 3'd1;
          end else if (act_t'(instr.action) == ACT_POP) begin
            hdr[hn] = OP_POP | {5'd0, dc[2:0]}; hn = hn + 3'd1;
          end else begin
            hdr[hn] = OP_PUSH | {5'd0, dc[2:0]}; hn = hn + 3'd1;
          end
        end
      end
      ACT_LEA: begin
        if ((d64 || d32 || d16) && (s64 || s32) && f32) begin
          ok = 1'b1;
          if (s32) begin
            hdr[hn] = PFX_ADDRSIZE; hn = hn + 3'd1;
          end
          if (d16) begin
            hdr[hn] = PFX_OPSIZE; hn = hn + 3'd1;
          end
          if (|lrex) begin
            hdr[hn] = REX_BASE | {4'd0, lrex}; hn = hn + 3'd1;
          end
          hdr[hn] = OP_LEA; hn = hn + 3'd1;
          // zero displacement drops out unless the base needs disp form
          if (imm[31:0] == 32'd0 && sc[2:0] != RM_DISP_ONLY) lmod = 2'd0;
          else if (f8) lmod = 2'd1;
          else lmod = 2'd2;
          hdr[hn] = {lmod, dc[2:0], sc[2:0]}; hn = hn + 3'd1;
          if (sc[2:0] == RM_SIB) begin
            hdr[hn] = SIB_NOINDEX; hn = hn + 3'd1;
          end
          il = (lmod == 2'd1) ? 4'd1 : (lmod == 2'd2) ? 4'd4 : 4'd0;
        end
      end
      ACT_LEAVE: begin
        ok = 1'b1; hdr[0] = OP_LEAVE; hn = 3'd1;
      end
      ACT_RET: begin
        ok = 1'b1; hdr[0] = OP_RET; hn = 3'd1;
      end
      ACT_MOV_IMM: begin
        if (d64) begin
          ok = 1'b1;
          hdr[0] = REX_W | {7'd0, dc[3]}; hdr[1] = OP_MOV_IMM | {5'd0, dc[2:0]};
          hn = 3'd2; il = 4'd8;
        end else if (d32 && f32) begin
          ok = 1'b1; hdr[0] = OP_MOV_IMM | {5'd0, dc[2:0]}; hn = 3'd1; il = 4'd4;
        end else if (d16 && f16) begin
          ok = 1'b1;
          hdr[0] = PFX_OPSIZE; hdr[1] = OP_MOV_IMM | {5'd0, dc[2:0]};
          hn = 3'd2; il = 4'd2;
        end else if (d8 && f8) begin
          ok = 1'b1; hdr[0] = OP_MOV_IMM_B | {5'd0, dc[2:0]}; hn = 3'd1; il = 4'd1;
        end
      end
      ACT_MOV_REG: begin
        if (d64 && s64) begin
          ok = 1'b1;
          hdr[0] = REX_W | {5'd0, sc[3], 1'b0, dc[3]}; hdr[1] = OP_MOV_RM;
          hdr[2] = {2'b11, sc[2:0], dc[2:0]}; hn = 3'd3;
        end else if (d32 && s32) begin
          ok = 1'b1;
          hdr[0] = OP_MOV_RM; hdr[1] = {2'b11, sc[2:0], dc[2:0]}; hn = 3'd2;
        end else if (d16 && src >= REG_AX && src <= R16_LAST) begin
          ok = 1'b1;
          hdr[0] = PFX_OPSIZE; hdr[1] = OP_MOV_RM;
          hdr[2] = {2'b11, sc[2:0], dc[2:0]}; hn = 3'd3;
        end else if (d8 && src >= REG_AL && src <= R8_LAST) begin
          ok = 1'b1;
          hdr[0] = OP_MOV_RM_B; hdr[1] = {2'b11, sc[2:0], dc[2:0]}; hn = 3'd2;
        end
      end
      ACT_MOVQ: begin
        if ((dxmm && s64) || (sxmm && d64)) begin
          ok = 1'b1;
          hdr[0] = PFX_OPSIZE;
          hdr[1] = REX_W | {5'd0, xc[3], 1'b0, gc[3]};
          hdr[2] = OP_ESC;
          hdr[3] = opq;
          hdr[4] = MODRM_REG | {2'b00, xc[2:0], gc[2:0]};
          hn = 3'd5;
        end
      end
      default: ok = 1'b0;
    endcase
  end

  // header bytes first, then the immediate little endian
  always_comb begin
    wr.push   = instr.valid && !full;
    wr.rec.ok = ok;
    wr.rec.len = ok ? ({1'b0, hn} + il) : 4'd1;
    j = 4'd0;
    for (int k = 0; k < MaxBytes; k++) begin
      j = 4'(k) - {1'b0, hn};
      if (!ok) wr.rec.bytes[k] = 8'h00;
      else if (4'(k) < {1'b0, hn}) wr.rec.bytes[k] = hdr[3'(k)];
      else wr.rec.bytes[k] = imm[{j[2:0], 3'b000} +: 8];
    end
  end

  assign instr.ready = !full;

endmodule

### hdl/x86enc_queue.sv
// short record queue between the encoder front and the byte serializer
// depends on x86enc_pkg
module x86enc_queue
  import x86enc_pkg::*;
#(
  parameter int Depth = DefQueueDepth
) (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t wr,
  input  logic  pop,
  output logic  full,
  output q_rd_t rd
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  enc_rec_t      mem [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] cnt;
  logic            do_push, do_pop;

  assign full    = cnt == CntW'(Depth);
  assign do_push = wr.push && !full;
  assign do_pop  = pop && (cnt != '0);

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wr.rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (do_pop) rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

  assign rd.valid = cnt != '0;
  assign rd.rec   = mem[rptr];

endmodule

### hdl/x86enc_back.sv
// back end: walks the head record and drives one code byte per transfer
// depends on x86enc_pkg and x86enc_if
module x86enc_back
  import x86enc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  q_rd_t rd,
  output logic  pop,
  x86enc_byte_if.source code
);

  logic [3:0] idx;
  logic       ovalid;
  logic [7:0] obyte;
  logic       olast, ook;
  logic       load, at_last;

  assign load    = rd.valid && (!ovalid || code.ready);
  assign at_last = idx == (rd.rec.len - 4'd1);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= 4'd0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= at_last ? 4'd0 : idx + 4'd1;
      end else if (code.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= rd.rec.bytes[idx];
      olast <= at_last;
      ook   <= rd.rec.ok;
    end
  end

  assign code.valid     = ovalid;
  assign code.out_byte  = obyte;
  assign code.last_byte = olast;
  assign code.ok        = ook;

endmodule

### hdl/x86enc_checker.sv
// port-level checks on the code channel of the instruction encoder
// depends on x86_64_instruction_encoder_unit_assert.svh and the top level
`include "x86_64_instruction_encoder_unit_assert.svh"

module x86enc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_ok
);

  // a stalled byte holds
  `X86ENC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_ok))

  // a rejected request is one zero byte
  `X86ENC_ASSERT_NOW(a_reject, clk, rst, out_valid && !out_ok, out_last && out_byte == 8'h00)

  // only valid encodings run over several bytes
  `X86ENC_ASSERT_NOW(a_multi, clk, rst, out_valid && !out_last, out_ok)

  // nothing shows right after a reset cycle
  `X86ENC_ASSERT_NEXT(a_reset, clk, 1'b0, rst, !out_valid)

endmodule

bind x86_64_instruction_encoder_unit x86enc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (code.valid),
  .out_ready (code.ready),
  .out_byte  (code.out_byte),
  .out_last  (code.last_byte),
  .out_ok    (code.ok)
);

### sim/encoder_code_check.sv
`timescale 1ns / 100ps
// watches both channels of the instruction encoder, works out the machine code
// of every accepted request and compares it byte by byte with the code channel
// depends on x86enc_pkg and the channel interfaces in x86enc_if
module encoder_code_check
  import x86enc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  x86enc_req_if  instr,
  x86enc_byte_if code,
  output int     failures,
  output int     pending
);

  localparam logic [7:0] BYTE_REX        = 8'h40;
  localparam logic [7:0] BYTE_REX_B      = 8'h41;
  localparam logic [7:0] BYTE_REX_W      = 8'h48;
  localparam logic [7:0] BYTE_OPSIZE     = 8'h66;
  localparam logic [7:0] BYTE_ADDRSIZE   = 8'h67;
  localparam logic [7:0] BYTE_AND_AL     = 8'h24;
  localparam logic [7:0] BYTE_AND_EAX    = 8'h25;
  localparam logic [7:0] BYTE_GRP1_IMM8  = 8'h80;
  localparam logic [7:0] BYTE_GRP1_IMM   = 8'h81;
  localparam logic [7:0] BYTE_GRP1_SX8   = 8'h83;
  localparam logic [7:0] BYTE_MODRM_AND  = 8'hE0;
  localparam logic [7:0] BYTE_LEA        = 8'h8D;
  localparam logic [7:0] BYTE_SIB_BASE   = 8'h24;
  localparam logic [7:0] BYTE_MOV_IMM8   = 8'hB0;
  localparam logic [7:0] BYTE_MOV_IMM    = 8'hB8;
  localparam logic [7:0] BYTE_MOV_RM8    = 8'h88;
  localparam logic [7:0] BYTE_MOV_RM     = 8'h89;
  localparam logic [7:0] BYTE_MODRM_RR   = 8'hC0;
  localparam logic [7:0] BYTE_GRP5       = 8'hFF;
  localparam logic [7:0] BYTE_MODRM_CALL = 8'hD0;
  localparam logic [7:0] BYTE_PUSH       = 8'h50;
  localparam logic [7:0] BYTE_POP        = 8'h58;
  localparam logic [7:0] BYTE_ESC        = 8'h0F;
  localparam logic [7:0] BYTE_MOVQ_LOAD  = 8'h6E;
  localparam logic [7:0] BYTE_MOVQ_STORE = 8'h7E;
  localparam logic [7:0] BYTE_RET        = 8'hC3;
  localparam logic [7:0] BYTE_LEAVE      = 8'hC9;
  localparam logic [2:0] LOW_SIB         = 3'd4;
  localparam logic [2:0] LOW_BP          = 3'd5;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       ok;
  } code_byte_t;

  code_byte_t expected_code[$];
  logic [7:0] code_buf[$];
  code_byte_t want;

  function automatic logic [2:0] gpr_low(logic [2:0] i);
    case (i)
      3'd0: return 3'd0;
      3'd1: return 3'd3;
      3'd2: return 3'd1;
      3'd3: return 3'd2;
      3'd4: return 3'd6;
      3'd5: return 3'd7;
      3'd6: return 3'd5;
      default: return 3'd4;
    endcase
  endfunction

  // al, bl, cl, dl, ah, bh, ch, dh
  function automatic logic [2:0] byte_low(logic [2:0] i);
    case (i)
      3'd0: return 3'd0;
      3'd1: return 3'd3;
      3'd2: return 3'd1;
      3'd3: return 3'd2;
      3'd4: return 3'd4;
      3'd5: return 3'd7;
      3'd6: return 3'd5;
      default: return 3'd6;
    endcase
  endfunction

  function automatic logic [3:0] hw_code(logic [6:0] r);
    if (r <= R64_LAST) return r[3] ? {1'b1, r[2:0]} : {1'b0, gpr_low(r[2:0])};
    if (r <= R16_LAST) return {1'b0, gpr_low(r[2:0])};
    if (r <= R8_LAST) return {1'b0, byte_low(r[2:0])};
    if (r <= MMX_LAST) return {1'b0, r[2:0]};
    if (r <= YMM_LAST) return r[3:0];
    return 4'd0;
  endfunction

  function automatic bit in_r64(logic [6:0] r);
    return r <= R64_LAST;
  endfunction

  function automatic bit in_r32(logic [6:0] r);
    return r >= REG_EAX && r <= R32_LAST;
  endfunction

  function automatic bit in_r16(logic [6:0] r);
    return r >= REG_AX && r <= R16_LAST;
  endfunction

  function automatic bit in_r8(logic [6:0] r);
    return r >= REG_AL && r <= R8_LAST;
  endfunction

  function automatic bit in_xmm(logic [6:0] r);
    return r >= XMM_BASE && r <= XMM_LAST;
  endfunction

  // two's complement value fits a signed field of the given width (below 64)
  function automatic bit fits_signed(logic [63:0] v, int bits);
    logic [63:0] half;
    half = 64'd1 << (bits - 1);
    return (v + half) < (64'd1 << bits);
  endfunction

  function automatic void emit_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) code_buf.push_back(v[8*i +: 8]);
  endfunction

  function automatic bit enc_and(logic [6:0] d, logic [63:0] imm);
    logic [3:0] c;
    logic [7:0] modrm, rex;
    c = hw_code(d);
    modrm = BYTE_MODRM_AND + {5'd0, c[2:0]};
    rex = BYTE_REX_W | {7'd0, c[3]};
    if (d > R8_LAST || !fits_signed(imm, 32)) return 1'b0;
    // accumulator short forms
    if (d == REG_AL && fits_signed(imm, 8)) begin
      code_buf.push_back(BYTE_AND_AL);
      emit_le(imm, 1);
      return 1'b1;
    end
    if (d == REG_AX && fits_signed(imm, 16)) begin
      code_buf.push_back(BYTE_OPSIZE);
      code_buf.push_back(BYTE_AND_EAX);
      emit_le(imm, 2);
      return 1'b1;
    end
    if (d == REG_EAX) begin
      code_buf.push_back(BYTE_AND_EAX);
      emit_le(imm, 4);
      return 1'b1;
    end
    if (d == REG_RAX) begin
      code_buf.push_back(BYTE_REX_W);
      code_buf.push_back(BYTE_AND_EAX);
      emit_le(imm, 4);
      return 1'b1;
    end
    if (fits_signed(imm, 8)) begin
      if (in_r8(d)) begin
        if (d >= REG_AH) return 1'b0;
        code_buf.push_back(BYTE_GRP1_IMM8);
      end else if (in_r16(d)) begin
        code_buf.push_back(BYTE_OPSIZE);
        code_buf.push_back(BYTE_GRP1_SX8);
      end else if (in_r32(d)) begin
        code_buf.push_back(BYTE_GRP1_SX8);
      end else begin
        code_buf.push_back(rex);
        code_buf.push_back(BYTE_GRP1_SX8);
      end
      code_buf.push_back(modrm);
      emit_le(imm, 1);
      return 1'b1;
    end
    if (in_r16(d) && fits_signed(imm, 16)) begin
      code_buf.push_back(BYTE_OPSIZE);
      code_buf.push_back(BYTE_GRP1_IMM);
      code_buf.push_back(modrm);
      emit_le(imm, 2);
      return 1'b1;
    end
    if (in_r8(d) || in_r16(d)) return 1'b0;
    if (!in_r32(d)) code_buf.push_back(rex);
    code_buf.push_back(BYTE_GRP1_IMM);
    code_buf.push_back(modrm);
    emit_le(imm, 4);
    return 1'b1;
  endfunction

  function automatic bit enc_lea(logic [6:0] d, logic [6:0] b, logic [63:0] disp);
    logic [3:0] dc, bc, rex_bits;
    logic [1:0] mode;
    dc = hw_code(d);
    bc = hw_code(b);
    if (!(in_r64(d) || in_r32(d) || in_r16(d))) return 1'b0;
    if (!(in_r64(b) || in_r32(b))) return 1'b0;
    if (!fits_signed(disp, 32)) return 1'b0;
    if (in_r32(b)) code_buf.push_back(BYTE_ADDRSIZE);
    if (in_r16(d)) code_buf.push_back(BYTE_OPSIZE);
    rex_bits = {in_r64(d), dc[3], 1'b0, bc[3]};
    if (rex_bits != 4'd0) code_buf.push_back(BYTE_REX | {4'd0, rex_bits});
    code_buf.push_back(BYTE_LEA);
    if (disp[31:0] == 32'd0 && bc[2:0] != LOW_BP) mode = 2'd0;
    else if (fits_signed(disp, 8)) mode = 2'd1;
    else mode = 2'd2;
    code_buf.push_back({mode, dc[2:0], bc[2:0]});
    if (bc[2:0] == LOW_SIB) code_buf.push_back(BYTE_SIB_BASE);
    if (mode == 2'd1) emit_le(disp, 1);
    else if (mode == 2'd2) emit_le(disp, 4);
    return 1'b1;
  endfunction

  function automatic bit enc_stack(logic [6:0] r, logic [7:0] op_base, bit is_call);
    logic [3:0] c;
    c = hw_code(r);
    if (!in_r64(r)) return 1'b0;
    if (c[3]) code_buf.push_back(BYTE_REX_B);
    if (is_call) begin
      code_buf.push_back(BYTE_GRP5);
      code_buf.push_back(BYTE_MODRM_CALL + {5'd0, c[2:0]});
    end else begin
      code_buf.push_back(op_base + {5'd0, c[2:0]});
    end
    return 1'b1;
  endfunction

  function automatic bit enc_mov_imm(logic [6:0] d, logic [63:0] v);
    logic [3:0] c;
    c = hw_code(d);
    if (in_r64(d)) begin
      code_buf.push_back(BYTE_REX_W | {7'd0, c[3]});
      code_buf.push_back(BYTE_MOV_IMM + {5'd0, c[2:0]});
      emit_le(v, 8);
      return 1'b1;
    end
    if (in_r32(d) && fits_signed(v, 32)) begin
      code_buf.push_back(BYTE_MOV_IMM + {5'd0, c[2:0]});
      emit_le(v, 4);
      return 1'b1;
    end
    if (in_r16(d) && fits_signed(v, 16)) begin
      code_buf.push_back(BYTE_OPSIZE);
      code_buf.push_back(BYTE_MOV_IMM + {5'd0, c[2:0]});
      emit_le(v, 2);
      return 1'b1;
    end
    if (in_r8(d) && fits_signed(v, 8)) begin
      code_buf.push_back(BYTE_MOV_IMM8 + {5'd0, c[2:0]});
      emit_le(v, 1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit enc_mov_reg(logic [6:0] d, logic [6:0] s);
    logic [3:0] dc, sc;
    logic [7:0] modrm;
    dc = hw_code(d);
    sc = hw_code(s);
    modrm = {2'b11, sc[2:0], dc[2:0]};
    if (in_r64(d) && in_r64(s)) begin
      code_buf.push_back(BYTE_REX_W | {5'd0, sc[3], 1'b0, dc[3]});
      code_buf.push_back(BYTE_MOV_RM);
    end else if (in_r32(d) && in_r32(s)) begin
      code_buf.push_back(BYTE_MOV_RM);
    end else if (in_r16(d) && in_r16(s)) begin
      code_buf.push_back(BYTE_OPSIZE);
      code_buf.push_back(BYTE_MOV_RM);
    end else if (in_r8(d) && in_r8(s)) begin
      code_buf.push_back(BYTE_MOV_RM8);
    end else begin
      return 1'b0;
    end
    code_buf.push_back(modrm);
    return 1'b1;
  endfunction

  // xmm always lands in modrm.reg, the gpr in modrm.rm
  function automatic bit enc_movq(logic [6:0] d, logic [6:0] s);
    logic [3:0] xc, gc;
    logic [7:0] op;
    if (in_xmm(d) && in_r64(s)) begin
      xc = hw_code(d);
      gc = hw_code(s);
      op = BYTE_MOVQ_LOAD;
    end else if (in_xmm(s) && in_r64(d)) begin
      xc = hw_code(s);
      gc = hw_code(d);
      op = BYTE_MOVQ_STORE;
    end else begin
      return 1'b0;
    end
    code_buf.push_back(BYTE_OPSIZE);
    code_buf.push_back(BYTE_REX_W | {5'd0, xc[3], 1'b0, gc[3]});
    code_buf.push_back(BYTE_ESC);
    code_buf.push_back(op);
    code_buf.push_back(BYTE_MODRM_RR + {2'b00, xc[2:0], gc[2:0]});
    return 1'b1;
  endfunction

  function automatic void encode_instruction(logic [3:0] act, logic [6:0] d, logic [6:0] s,
                                             logic [63:0] imm);
    bit good;
    int n;
    code_buf.delete();
    case (act)
      ACT_AND_IMM: good = enc_and(d, imm);
      ACT_CALL:    good = enc_stack(d, BYTE_GRP5, 1'b1);
      ACT_LEA:     good = enc_lea(d, s, imm);
      ACT_LEAVE: begin
        code_buf.push_back(BYTE_LEAVE);
        good = 1'b1;
      end
      ACT_MOV_IMM: good = enc_mov_imm(d, imm);
      ACT_MOV_REG: good = enc_mov_reg(d, s);
      ACT_MOVQ:    good = enc_movq(d, s);
      ACT_POP:     good = enc_stack(d, BYTE_POP, 1'b0);
      ACT_PUSH:    good = enc_stack(d, BYTE_PUSH, 1'b0);
      ACT_RET: begin
        code_buf.push_back(BYTE_RET);
        good = 1'b1;
      end
      default:     good = 1'b0;
    endcase
    n = code_buf.size();
    if (!good || n == 0) begin
      expected_code.push_back('{value: 8'h00, last: 1'b1, ok: 1'b0});
    end else begin
      for (int i = 0; i < n; i++)
        expected_code.push_back('{value: code_buf[i], last: (i == n - 1), ok: 1'b1});
    end
  endfunction

  task automatic report_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
    failures = failures + 1;
    $error("%s mismatch: expected 0x%02h, actual 0x%02h", field, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_code.delete();
    end else begin
      // predict first, so a byte of a brand new request still lines up in order
      if (instr.valid && instr.ready)
        encode_instruction(instr.action, instr.dst_reg, instr.src_reg, instr.immediate);
      if (code.valid && code.ready) begin
        if (expected_code.size() == 0) begin
          failures = failures + 1;
          $error("code byte 0x%02h with no request outstanding", code.out_byte);
        end else begin
          want = expected_code.pop_front();
          if (code.out_byte !== want.value) report_field("out_byte", want.value, code.out_byte);
          if (code.last_byte !== want.last)
            report_field("last_byte", {7'd0, want.last}, {7'd0, code.last_byte});
          if (code.ok !== want.ok) report_field("ok", {7'd0, want.ok}, {7'd0, code.ok});
        end
      end
    end
    pending = expected_code.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// top of the instruction encoder testbench: clock, reset, request stimulus,
// backpressure on the code side, watchdog and verdict
// depends on x86enc_pkg, x86enc_if, encoder_code_check and the encoder top level
module tb;
  import x86enc_pkg::*;

  // random requests per idling phase, four phases
  localparam int RANDOM_PER_PHASE = 111;
  // cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // settle time after the last byte, well past the queue and the output register
  localparam int DRAIN_PAD = 16;
  localparam logic [3:0] ACT_TOP_CODE = 4'hF;

  // named registers used by the directed requests
  localparam logic [6:0] R_RDX   = 7'd3;
  localparam logic [6:0] R_RSP   = 7'd7;
  localparam logic [6:0] R_R8    = 7'd8;
  localparam logic [6:0] R_R9    = 7'd9;
  localparam logic [6:0] R_R12   = 7'd12;
  localparam logic [6:0] R_R13   = 7'd13;
  localparam logic [6:0] R_R15   = 7'd15;
  localparam logic [6:0] R_EBP   = 7'd22;
  localparam logic [6:0] R_BX    = 7'd25;
  localparam logic [6:0] R_CL    = 7'd34;
  localparam logic [6:0] R_DL    = 7'd35;
  localparam logic [6:0] R_XMM15 = 7'd63;
  localparam logic [6:0] R_NONE  = 7'd127;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // percent of cycles the request side holds off / the code side stalls
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  int failures;
  int pending;
  int quiet_cycles;

  x86enc_req_if  instr ();
  x86enc_byte_if code ();

  x86_64_instruction_encoder_unit uut (
    .clk  (clk),
    .rst  (rst),
    .instr(instr),
    .code (code)
  );

  // prediction and comparison live beside the block, this module only drives
  encoder_code_check code_check (
    .clk     (clk),
    .rst     (rst),
    .instr   (instr),
    .code    (code),
    .failures(failures),
    .pending (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // code-side backpressure, redrawn every falling edge
  always @(negedge clk) begin
    code.ready <= (receiver_stall_pct == 0) || ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // one request transfer; entered and left at a falling edge so valid is
  // never lowered and raised in the same step
  task automatic send_request(input logic [3:0] act, input logic [6:0] d,
                              input logic [6:0] s, input logic [63:0] imm);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      instr.valid <= 1'b0;
      @(negedge clk);
    end
    instr.valid     <= 1'b1;
    instr.action    <= act;
    instr.dst_reg   <= d;
    instr.src_reg   <= s;
    instr.immediate <= imm;
    do @(posedge clk); while (!instr.ready);
    @(negedge clk);
  endtask

  // mostly sign-extended narrow values, with the field boundaries around
  // 8, 16, 32 and 64 bits and fully random words mixed in
  function automatic logic [63:0] random_immediate();
    logic [31:0] w;
    logic [63:0] half;
    logic [63:0] v;
    int k;
    w = $urandom;
    case ($urandom_range(0, 6))
      0: v = {{56{w[7]}}, w[7:0]};
      1: v = {{48{w[15]}}, w[15:0]};
      2: v = {{32{w[31]}}, w};
      3: v = {$urandom, $urandom};
      4: begin
        k = 8 << $urandom_range(0, 3);
        half = 64'd1 << (k - 1);
        case ($urandom_range(0, 3))
          0: v = half - 64'd1;
          1: v = ~half + 64'd1;
          2: v = half;
          default: v = ~half;
        endcase
      end
      5: begin
        v = 64'($urandom_range(0, 4));
        v = v - 64'd2;
      end
      default: v = {57'd0, w[6:0]};
    endcase
    return v;
  endfunction

  // register from the class the operation wants, now and then any index at all
  function automatic logic [6:0] random_reg(logic [6:0] lo, logic [6:0] hi);
    if ($urandom_range(0, 99) < 12) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(lo, hi));
  endfunction

  task automatic send_random_request();
    logic [3:0] act;
    logic [6:0] d;
    logic [6:0] s;
    logic [63:0] imm;
    if ($urandom_range(0, 99) < 4) act = 4'($urandom_range(ACT_RET + 1, ACT_TOP_CODE));
    else act = 4'($urandom_range(ACT_AND_IMM, ACT_RET));
    d = 7'($urandom_range(0, 127));
    s = 7'($urandom_range(0, 127));
    imm = random_immediate();
    case (act)
      ACT_AND_IMM, ACT_MOV_IMM: d = random_reg(REG_RAX, R8_LAST);
      ACT_CALL, ACT_POP, ACT_PUSH: d = random_reg(REG_RAX, R64_LAST);
      ACT_LEA: begin
        d = random_reg(REG_RAX, R16_LAST);
        s = random_reg(REG_RAX, R32_LAST);
      end
      ACT_MOV_REG: begin
        // same-width pairs, otherwise almost everything is rejected
        case ($urandom_range(0, 3))
          0: begin
            d = random_reg(REG_RAX, R64_LAST);
            s = random_reg(REG_RAX, R64_LAST);
          end
          1: begin
            d = random_reg(REG_EAX, R32_LAST);
            s = random_reg(REG_EAX, R32_LAST);
          end
          2: begin
            d = random_reg(REG_AX, R16_LAST);
            s = random_reg(REG_AX, R16_LAST);
          end
          default: begin
            d = random_reg(REG_AL, R8_LAST);
            s = random_reg(REG_AL, R8_LAST);
          end
        endcase
      end
      ACT_MOVQ: begin
        if ($urandom_range(0, 1) == 0) begin
          d = random_reg(XMM_BASE, XMM_LAST);
          s = random_reg(REG_RAX, R64_LAST);
        end else begin
          d = random_reg(REG_RAX, R64_LAST);
          s = random_reg(XMM_BASE, XMM_LAST);
        end
      end
      default: ;
    endcase
    send_request(act, d, s, imm);
  endtask

  // field extremes, every operation and a set of rejection rules
  task automatic run_directed();
    // and: accumulator short forms at their range limits
    send_request(ACT_AND_IMM, REG_AL, REG_RAX, 64'd127);
    send_request(ACT_AND_IMM, REG_AX, REG_RAX, 64'hFFFF_FFFF_FFFF_8000);
    send_request(ACT_AND_IMM, REG_EAX, REG_RAX, 64'h0000_0000_7FFF_FFFF);
    send_request(ACT_AND_IMM, REG_RAX, REG_RAX, 64'hFFFF_FFFF_8000_0000);
    // and: high byte register, too wide an immediate for a byte, out of int32
    send_request(ACT_AND_IMM, REG_AH, REG_RAX, 64'd1);
    send_request(ACT_AND_IMM, R_CL, REG_RAX, 64'd200);
    send_request(ACT_AND_IMM, REG_RAX, REG_RAX, 64'h0000_0000_8000_0000);
    // and: sign-extended imm8 and rex.b with imm32
    send_request(ACT_AND_IMM, R_BX, REG_RAX, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_AND_IMM, R_R15, REG_RAX, 64'h0000_0000_1234_5678);
    send_request(ACT_CALL, R_R9, REG_RAX, 64'd0);
    // register index past every class
    send_request(ACT_CALL, R_NONE, REG_RAX, 64'd0);
    // lea: sib base with disp8 floor, 32-bit base with 16-bit dest, rbp-like
    // base with zero disp, r13 base with disp32, bad dest, disp out of range
    send_request(ACT_LEA, R_R12, R_RSP, 64'hFFFF_FFFF_FFFF_FF80);
    send_request(ACT_LEA, REG_AX, R_EBP, 64'd0);
    send_request(ACT_LEA, R_RDX, R_R13, 64'd128);
    send_request(ACT_LEA, XMM_BASE, REG_RAX, 64'd0);
    send_request(ACT_LEA, REG_RAX, REG_RAX, 64'h0000_0000_8000_0000);
    send_request(ACT_LEAVE, REG_RAX, REG_RAX, 64'd0);
    send_request(ACT_MOV_IMM, REG_RAX, REG_RAX, 64'h8000_0000_0000_0000);
    send_request(ACT_MOV_IMM, R_DL, REG_RAX, 64'd128);
    send_request(ACT_MOV_IMM, R_CL, REG_RAX, 64'hFFFF_FFFF_FFFF_FF80);
    send_request(ACT_MOV_REG, R_R15, R_R8, 64'd0);
    send_request(ACT_MOV_REG, REG_EAX, REG_AX, 64'd0);
    send_request(ACT_MOVQ, R_XMM15, R_R15, 64'd0);
    send_request(ACT_MOVQ, R_R8, XMM_BASE, 64'd0);
    send_request(ACT_POP, R_R8, REG_RAX, 64'd0);
    send_request(ACT_PUSH, REG_RAX, REG_RAX, 64'd0);
    send_request(ACT_RET, R_NONE, R_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_TOP_CODE, REG_RAX, REG_RAX, 64'd0);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (RANDOM_PER_PHASE) send_random_request();
  endtask

  // stimulus and verdict
  initial begin
    instr.valid     = 1'b0;
    instr.action    = ACT_AND_IMM;
    instr.dst_reg   = REG_RAX;
    instr.src_reg   = REG_RAX;
    instr.immediate = 64'd0;
    code.ready      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    // free flowing, then request gaps, then code stalls, then both
    run_phase(0, 0);
    run_phase(51, 0);
    run_phase(0, 51);
    run_phase(34, 34);
    instr.valid <= 1'b0;

    // drain every outstanding byte, then give stray bytes a chance to show
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang detection: reset or any cycle with a transfer on either channel resets the count
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (instr.valid && instr.ready) || (code.valid && code.ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
    end
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/x86enc_pkg.sv
hdl/x86enc_if.sv
hdl/x86enc_front.sv
hdl/x86enc_queue.sv
hdl/x86enc_back.sv
hdl/x86_64_instruction_encoder_unit.sv
hdl/x86enc_checker.sv
sim/encoder_code_check.sv
sim/tb.sv
